// File: rtl/glpd_pkg.sv
// Shared types, constants and helpers of the grid local peak detector.
package glpd_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
    localparam int SIZE_BITS    = 11;
    localparam int CFG_IDX_BITS = 2;
    localparam int MIN_SIZE     = 2;

    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    // Input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // One line buffer word: most recent row and the row before it
    typedef struct packed {
        sample_t prev;
        sample_t older;
    } line_entry_t;

    // One neighbor tap: whether the neighbor exists, and its value
    typedef struct packed {
        logic    present;
        sample_t sample;
    } tap_t;

    // One decision as it leaves the block
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                peak;
        logic                last;
    } result_t;

    // Limit a written frame size to the supported range
    function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                        input logic [SIZE_BITS-1:0] hi);
        logic [SIZE_BITS-1:0] r;
        if (v < SIZE_BITS'(MIN_SIZE)) begin
            r = SIZE_BITS'(MIN_SIZE);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// File: rtl/grid_local_peak_detector.sv
// Top level of the grid local peak detector: counters, line buffer, window cells, result queue.
//
// Usage:
//   s_ channel: one transaction per grid sample in raster order (s_kind = pixel), then
//   frame_width drain transactions (s_kind = drain) that decide the last row. A pixel of
//   row r yields the decision for cell (r-1, c); first-row pixels yield nothing. Pixels
//   arriving while the frame drains, and drains arriving before the last row, are taken
//   and dropped.
//   m_ channel: one transaction per decision: row, column, peak flag, frame_last on the
//   final cell of the frame.
//   cfg_ channel: always ready; index 0 writes frame_width, index 1 frame_height (both clamped
//   to 2..1024). A write to either restarts the frame. Write only while no item is in flight.
// Path: a decision passes stage 1, stage 2 and the result queue before it is offered on m_.
// Throughput: one input transaction per cycle while s_ready is high, set by the line buffer
//   RAM with one write and two read ports serving every sample once.
// Reset: counters, pipeline and result queue clear; sizes return to 1024 x 1024. The line
//   buffer is not cleared: a frame reads only entries it wrote itself.
// Stall: a four-entry result queue absorbs the pipeline; s_ready drops when the queue plus
//   the items in flight would fill it, so nothing is lost while m_ready is low.
module grid_local_peak_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  glpd_pkg::sample_t                   s_pixel_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [glpd_pkg::ROW_BITS-1:0]       m_cell_row,
    output logic [glpd_pkg::COL_BITS-1:0]       m_cell_col,
    output logic                                m_is_peak,
    output logic                                m_frame_last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [glpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [glpd_pkg::SIZE_BITS-1:0]      cfg_data
);

    import glpd_pkg::*;

    // Frame size and position
    logic [SIZE_BITS-1:0] width_reg, width_next;
    logic [SIZE_BITS-1:0] height_reg, height_next;
    logic [COL_BITS-1:0]  col_reg, col_next;
    logic [ROW_BITS-1:0]  row_reg, row_next;
    logic [COL_BITS-1:0]  drain_reg, drain_next;
    logic                 all_rows_in_reg, all_rows_in_next;

    // Intake decode
    logic                 accept;
    logic                 is_pixel;
    logic                 take;
    logic [COL_BITS-1:0]  cur_col;
    logic                 col_last;
    logic                 row_last;
    logic                 cfg_write;

    // Line buffer
    logic [COL_BITS-1:0]  rd_addr_a, rd_addr_b;
    line_entry_t          rd_entry_a, rd_entry_b;
    logic                 wr_en;
    line_entry_t          wr_entry;

    // Stage 1: line buffer data aligned with the item
    logic                 s1_valid_reg;
    logic                 s1_res_reg;
    logic                 s1_pixel_reg;
    logic [ROW_BITS-1:0]  s1_row_reg;
    logic [COL_BITS-1:0]  s1_col_reg;
    logic                 s1_last_reg;
    logic                 s1_has_left_reg;
    logic                 s1_has_right_reg;
    logic                 s1_has_up_reg;
    sample_t              s1_down_reg;
    logic                 fwd_reg, fwd_next;
    sample_t              fwd_data_reg;
    sample_t              right_val;

    // Stage 2: window cells
    logic                 s2_res_reg;
    logic [ROW_BITS-1:0]  s2_row_reg;
    logic [COL_BITS-1:0]  s2_col_reg;
    logic                 s2_last_reg;
    sample_t              s2_center_reg;
    logic                 left_ok, up_ok, right_ok, down_ok;
    tap_t                 left_in, up_in, right_in, down_in;

    // Result queue
    result_t                 push_data;
    result_t                 pop_data;
    logic [OUT_CNT_BITS-1:0] out_count;
    logic [OUT_CNT_BITS-1:0] in_flight;

    // Decode the offered item
    assign accept    = s_valid && s_ready;
    assign is_pixel  = (s_kind == KIND_PIXEL);
    assign take      = accept && (is_pixel ? !all_rows_in_reg : all_rows_in_reg);
    assign cur_col   = is_pixel ? col_reg : drain_reg;
    assign col_last  = ({1'b0, cur_col} == (width_reg - SIZE_BITS'(1)));
    assign row_last  = ({1'b0, row_reg} == (height_reg - SIZE_BITS'(1)));
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Hold back intake while the queue could overflow
    assign in_flight = OUT_CNT_BITS'(s1_valid_reg && s1_res_reg)
                     + OUT_CNT_BITS'(s2_res_reg) + out_count;
    assign s_ready   = (in_flight < OUT_CNT_BITS'(OUT_DEPTH));

    // Step the frame position
    always_comb begin
        width_next       = width_reg;
        height_next      = height_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        drain_next       = drain_reg;
        all_rows_in_next = all_rows_in_reg;
        if (cfg_write) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                width_next = clamp_size(cfg_data, SIZE_BITS'(MAX_WIDTH));
            end else if (cfg_index == REG_FRAME_HEIGHT) begin
                height_next = clamp_size(cfg_data, SIZE_BITS'(MAX_HEIGHT));
            end
            if ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT)) begin
                col_next         = '0;
                row_next         = '0;
                drain_next       = '0;
                all_rows_in_next = 1'b0;
            end
        end else if (take && is_pixel) begin
            if (col_last) begin
                col_next = '0;
                if (row_last) begin
                    all_rows_in_next = 1'b1;
                    row_next         = '0;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end else if (take) begin
            if (col_last) begin
                drain_next       = '0;
                all_rows_in_next = 1'b0;
            end else begin
                drain_next = drain_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg       <= SIZE_BITS'(MAX_WIDTH);
            height_reg      <= SIZE_BITS'(MAX_HEIGHT);
            col_reg         <= '0;
            row_reg         <= '0;
            drain_reg       <= '0;
            all_rows_in_reg <= 1'b0;
        end else begin
            width_reg       <= width_next;
            height_reg      <= height_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            drain_reg       <= drain_next;
            all_rows_in_reg <= all_rows_in_next;
        end
    end

    // Read the center column and its right neighbor
    assign rd_addr_a = cur_col;
    assign rd_addr_b = cur_col + 1'b1;

    glpd_ram #(
        .WIDTH($bits(line_entry_t)),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .aclk      (aclk),
        .wr_en     (wr_en),
        .wr_addr   (s1_col_reg),
        .wr_data   (wr_entry),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_entry_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_entry_b)
    );

    // Stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_res_reg   <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= take;
            s1_res_reg   <= take && (is_pixel ? (row_reg != '0) : 1'b1);
            fwd_reg      <= fwd_next;
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (take) begin
            s1_pixel_reg     <= is_pixel;
            s1_row_reg       <= is_pixel ? (row_reg - 1'b1)
                                         : ROW_BITS'(height_reg - SIZE_BITS'(1));
            s1_col_reg       <= cur_col;
            s1_last_reg      <= !is_pixel && col_last;
            s1_has_left_reg  <= (cur_col != '0);
            s1_has_right_reg <= !col_last;
            s1_has_up_reg    <= is_pixel ? (row_reg >= ROW_BITS'(2)) : 1'b1;
            s1_down_reg      <= s_pixel_value;
        end
        fwd_data_reg <= wr_entry.prev;
    end

    // Rotate the column: the old newest row becomes the older row
    assign wr_en             = s1_valid_reg;
    assign wr_entry.prev     = s1_pixel_reg ? s1_down_reg : rd_entry_a.prev;
    assign wr_entry.older    = rd_entry_a.prev;

    // Forward a column written in the same cycle as its read
    assign fwd_next  = s1_valid_reg && (s1_col_reg == rd_addr_b);
    assign right_val = fwd_reg ? fwd_data_reg : rd_entry_b.prev;

    // Load the window cells; the left cell takes the previous center
    assign left_in  = '{present: s1_has_left_reg,  sample: s2_center_reg};
    assign up_in    = '{present: s1_has_up_reg,    sample: rd_entry_a.older};
    assign right_in = '{present: s1_has_right_reg, sample: right_val};
    assign down_in  = '{present: s1_pixel_reg,     sample: s1_down_reg};

    glpd_cell u_left_cell (
        .aclk(aclk), .load(s1_valid_reg), .tap_in(left_in), .center(s2_center_reg),
        .center_ok(left_ok)
    );

    glpd_cell u_up_cell (
        .aclk(aclk), .load(s1_valid_reg), .tap_in(up_in), .center(s2_center_reg),
        .center_ok(up_ok)
    );

    glpd_cell u_right_cell (
        .aclk(aclk), .load(s1_valid_reg), .tap_in(right_in), .center(s2_center_reg),
        .center_ok(right_ok)
    );

    glpd_cell u_down_cell (
        .aclk(aclk), .load(s1_valid_reg), .tap_in(down_in), .center(s2_center_reg),
        .center_ok(down_ok)
    );

    // Stage 2 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_res_reg <= 1'b0;
        end else begin
            s2_res_reg <= s1_valid_reg && s1_res_reg;
        end
    end

    // Stage 2 payload
    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            s2_center_reg <= rd_entry_a.prev;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // Combine the neighbor checks into one decision
    assign push_data.row  = s2_row_reg;
    assign push_data.col  = s2_col_reg;
    assign push_data.peak = left_ok && up_ok && right_ok && down_ok;
    assign push_data.last = s2_last_reg;

    glpd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s2_res_reg),
        .push_data (push_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .pop_data  (pop_data),
        .count     (out_count)
    );

    assign m_cell_row   = pop_data.row;
    assign m_cell_col   = pop_data.col;
    assign m_is_peak    = pop_data.peak;
    assign m_frame_last = pop_data.last;

endmodule

// File: rtl/glpd_ram.sv
// Generic RAM: one write port, two registered read ports, old data on a same-address read.
module glpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read both ports every cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// File: rtl/glpd_cell.sv
// Neighbor cell of the comparison window: holds one neighbor and checks the center against it.
module glpd_cell (
    input  logic             aclk,
    input  logic             load,
    input  glpd_pkg::tap_t   tap_in,
    input  glpd_pkg::sample_t center,
    output logic             center_ok
);

    import glpd_pkg::*;

    tap_t tap_reg;

    // Take the new neighbor when the window advances
    always_ff @(posedge aclk) begin
        if (load) begin
            tap_reg <= tap_in;
        end
    end

    // A missing neighbor never blocks a peak
    assign center_ok = !tap_reg.present || (center >= tap_reg.sample);

endmodule

// File: rtl/glpd_out_buf.sv
// Result queue in front of the m_ channel; decouples the pipeline from receiver stalls.
module glpd_out_buf (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  glpd_pkg::result_t                  push_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output glpd_pkg::result_t                  pop_data,
    output logic [glpd_pkg::OUT_CNT_BITS-1:0]  count
);

    import glpd_pkg::*;

    result_t                 entry_reg [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_BITS-1:0] count_reg, count_next;
    logic                    pop;

    assign m_valid  = (count_reg != '0);
    assign pop      = m_valid && m_ready;
    assign pop_data = entry_reg[rd_ptr_reg];
    assign count    = count_reg;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_BITS'(OUT_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed results
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/glpd_checker.sv
// Port-level checker for the grid local peak detector, bound to the top level.
module glpd_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic [glpd_pkg::ROW_BITS-1:0]      m_cell_row,
    input logic [glpd_pkg::COL_BITS-1:0]      m_cell_col,
    input logic                               m_is_peak,
    input logic                               m_frame_last
);

    // No result survives reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered right after reset");

    // A stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cell_row) && $stable(m_cell_col)
            && $stable(m_is_peak) && $stable(m_frame_last))
        else $error("stalled result changed");

    // The final cell of a frame lies on a row below the first
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> (m_cell_row != '0))
        else $error("frame_last on the first row");

    // A result appearing on an empty queue comes from an accepted input transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 3))
        else $error("result without a matching input transaction");

endmodule

bind grid_local_peak_detector glpd_checker u_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_cell_row   (m_cell_row),
    .m_cell_col   (m_cell_col),
    .m_is_peak    (m_is_peak),
    .m_frame_last (m_frame_last)
);

// File: bench/tb.sv
// Self-checking bench for the grid local peak detector: predicted cell decisions and random traffic.
module tb;
    import glpd_pkg::*;

    localparam int RANDOM_ITEMS = 250;
    localparam int PIPE_SLACK   = 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int CFG_IDX_TOP  = (1 << CFG_IDX_BITS) - 1;

    // Line stores, frame position and expected decisions of the detector
    class peak_decision_board;
        sample_t              prev_line[MAX_WIDTH];
        sample_t              older_line[MAX_WIDTH];
        int unsigned          col_pos;
        int unsigned          row_pos;
        int unsigned          drain_pos;
        bit                   rows_done;
        logic [SIZE_BITS-1:0] width_reg;
        logic [SIZE_BITS-1:0] height_reg;
        result_t              decisions_due[$];
        int                   errors;

        function new();
            foreach (prev_line[i]) begin
                prev_line[i]  = '0;
                older_line[i] = '0;
            end
            width_reg  = SIZE_BITS'(MAX_WIDTH);
            height_reg = SIZE_BITS'(MAX_HEIGHT);
            errors     = 0;
            begin_frame();
        endfunction

        function void begin_frame();
            col_pos   = 0;
            row_pos   = 0;
            drain_pos = 0;
            rows_done = 1'b0;
        endfunction

        function int unsigned usable_size(logic [SIZE_BITS-1:0] v, int unsigned top);
            if (v < MIN_SIZE) return MIN_SIZE;
            if (v > top) return top;
            return v;
        endfunction

        function int unsigned frame_cols();
            return usable_size(width_reg, MAX_WIDTH);
        endfunction

        function int unsigned frame_rows();
            return usable_size(height_reg, MAX_HEIGHT);
        endfunction

        function bit at_frame_start();
            return col_pos == 0 && row_pos == 0 && drain_pos == 0 && !rows_done;
        endfunction

        // Any write to a known register restarts the frame; the line stores keep their data
        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [SIZE_BITS-1:0] data);
            if (idx == REG_FRAME_WIDTH) begin
                width_reg = data;
                begin_frame();
            end else if (idx == REG_FRAME_HEIGHT) begin
                height_reg = data;
                begin_frame();
            end
        endfunction

        // Cell c of the row held in prev_line; older_line holds the newer row left of c
        function bit judge_cell(int unsigned row, int unsigned c, int unsigned w,
                                bit has_down, sample_t down);
            sample_t center;
            bit      peak;
            center = prev_line[c];
            peak   = 1'b1;
            if (c > 0 && center < older_line[c - 1]) peak = 1'b0;
            if (c + 1 < w && center < prev_line[c + 1]) peak = 1'b0;
            if (row > 0 && center < older_line[c]) peak = 1'b0;
            if (has_down && center < down) peak = 1'b0;
            return peak;
        endfunction

        // Advance the frame by one accepted transaction; return 0 when it is dropped
        function bit accept_item(logic kind, sample_t value);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            int unsigned r;
            result_t     d;
            w = frame_cols();
            h = frame_rows();
            if (kind == KIND_PIXEL) begin
                if (rows_done) return 1'b0;
                c = col_pos;
                r = row_pos;
                if (r >= 1) begin
                    d.row  = ROW_BITS'(r - 1);
                    d.col  = COL_BITS'(c);
                    d.peak = judge_cell(r - 1, c, w, 1'b1, value);
                    d.last = 1'b0;
                    decisions_due.push_back(d);
                end
                older_line[c] = prev_line[c];
                prev_line[c]  = value;
                if (c + 1 >= w) begin
                    col_pos = 0;
                    if (r + 1 >= h) begin
                        rows_done = 1'b1;
                        row_pos   = 0;
                    end else begin
                        row_pos = r + 1;
                    end
                end else begin
                    col_pos = c + 1;
                end
                return 1'b1;
            end
            if (!rows_done) return 1'b0;
            c      = drain_pos;
            d.row  = ROW_BITS'(h - 1);
            d.col  = COL_BITS'(c);
            d.peak = judge_cell(h - 1, c, w, 1'b0, '0);
            d.last = (c + 1 >= w);
            decisions_due.push_back(d);
            older_line[c] = prev_line[c];
            if (d.last) begin
                begin_frame();
            end else begin
                drain_pos = c + 1;
            end
            return 1'b1;
        endfunction

        // Compare one result transaction with the oldest expected decision
        function void match_decision(logic [ROW_BITS-1:0] row, logic [COL_BITS-1:0] col,
                                     logic peak, logic last);
            result_t want;
            if (decisions_due.size() == 0) begin
                $error("decision for cell (%0d,%0d) with none outstanding", row, col);
                errors++;
                return;
            end
            want = decisions_due.pop_front();
            if (row !== want.row) begin
                $error("cell_row: expected %0d, actual %0d", want.row, row);
                errors++;
            end
            if (col !== want.col) begin
                $error("cell_col: expected %0d, actual %0d", want.col, col);
                errors++;
            end
            if (peak !== want.peak) begin
                $error("is_peak: expected %0b, actual %0b", want.peak, peak);
                errors++;
            end
            if (last !== want.last) begin
                $error("frame_last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic                    s_kind;
    sample_t                 s_pixel_value;
    logic                    m_valid;
    logic                    m_ready;
    logic [ROW_BITS-1:0]     m_cell_row;
    logic [COL_BITS-1:0]     m_cell_col;
    logic                    m_is_peak;
    logic                    m_frame_last;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [SIZE_BITS-1:0]    cfg_data;

    peak_decision_board board;
    int                 counted;
    int                 idle_cycles;
    bit                 quiet_sender;
    int                 sample_spread;

    grid_local_peak_detector dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_cell_row    (m_cell_row),
        .m_cell_col    (m_cell_col),
        .m_is_peak     (m_is_peak),
        .m_frame_last  (m_frame_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Abort when no transaction of any channel completes for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic sample_t random_sample();
        case (sample_spread)
            0: return sample_t'($urandom);
            1: return sample_t'($urandom_range(0, 4)) - sample_t'(2);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return sample_t'($urandom_range(0, 2));
                    default: return sample_t'($urandom);
                endcase
            end
        endcase
    endfunction

    function automatic logic [SIZE_BITS-1:0] rand_size();
        if ($urandom_range(0, 7) == 0) return SIZE_BITS'($urandom_range(9, 24));
        return SIZE_BITS'($urandom_range(2, 8));
    endfunction

    // Offer one input transaction after a random gap and hold it until accepted
    task automatic send_item(input logic kind, input sample_t value);
        int gap;
        if ($urandom_range(0, 49) == 0) quiet_sender = !quiet_sender;
        gap = quiet_sender ? 0 : $urandom_range(0, 16);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_pixel_value <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (board.accept_item(kind, value)) counted++;
    endtask

    // Hold the input side until every expected decision has come out
    task automatic wait_decisions_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.decisions_due.size() != 0) @(negedge aclk);
    endtask

    // Drain the block completely, including items that give no result
    task automatic settle();
        wait_decisions_drained();
        repeat (PIPE_SLACK) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [SIZE_BITS-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        board.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Send a frame in raster order plus its drain ticks, optionally cut short or salted
    // with transactions the block must drop
    task automatic send_frame(input int stop_after, input bit noisy);
        int w;
        int h;
        int total;
        int n;
        w     = board.frame_cols();
        h     = board.frame_rows();
        total = w * h + w;
        for (n = 0; n < total && (stop_after < 0 || n < stop_after); n++) begin
            if (noisy && $urandom_range(0, 29) == 0) begin
                send_item(n < w * h ? KIND_DRAIN : KIND_PIXEL, random_sample());
            end
            if ($urandom_range(0, 149) == 0) wait_decisions_drained();
            send_item(n < w * h ? KIND_PIXEL : KIND_DRAIN, random_sample());
        end
    endtask

    // Accept and check results after a random stall per transaction
    initial begin
        int stall;
        bit quiet;
        m_ready = 1'b0;
        quiet   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 39) == 0) quiet = !quiet;
            stall = quiet ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            board.match_decision(m_cell_row, m_cell_col, m_is_peak, m_frame_last);
        end
    end

    initial begin
        sample_t grid_3x3[9];
        int      i;
        int      pick;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_kind        = KIND_PIXEL;
        s_pixel_value = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_FRAME_WIDTH;
        cfg_data      = '0;
        idle_cycles   = 0;
        counted       = 0;
        quiet_sender  = 1'b0;
        sample_spread = 2;
        board         = new();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset sizes: start a wide first row, drop an early drain, then restart by a write
        send_item(KIND_PIXEL, 16'sh1234);
        send_item(KIND_PIXEL, 16'shedcb);
        send_item(KIND_DRAIN, 16'sh0000);
        settle();
        write_reg(REG_FRAME_WIDTH, 11'd3);
        write_reg(REG_FRAME_HEIGHT, 11'd3);

        // Extremes and ties in a 3x3 frame, with an early drain and a pixel while draining
        grid_3x3 = '{16'sh7fff, 16'sh8000, 16'sh0000,
                     16'shffff, 16'sh7fff, 16'sh7fff,
                     16'sh8000, 16'sh0005, 16'sh7fff};
        for (i = 0; i < 9; i++) begin
            if (i == 4) wait_decisions_drained();
            if (i == 6) send_item(KIND_DRAIN, 16'sh7fff);
            send_item(KIND_PIXEL, grid_3x3[i]);
        end
        send_item(KIND_DRAIN, 16'sh0000);
        send_item(KIND_PIXEL, 16'sh8000);
        send_item(KIND_DRAIN, 16'shffff);
        send_item(KIND_DRAIN, 16'sh0000);
        settle();

        // Sizes below the minimum clamp to 2x2; flat frame, then a back-to-back frame
        write_reg(REG_FRAME_WIDTH, 11'd0);
        write_reg(REG_FRAME_HEIGHT, 11'd1);
        repeat (4) send_item(KIND_PIXEL, -16'sd5);
        repeat (2) send_item(KIND_DRAIN, 16'sh0000);
        send_frame(-1, 1'b0);

        // Random phases: mostly whole frames, some cut short, some stray transactions
        while (counted < RANDOM_ITEMS) begin
            settle();
            if (!board.at_frame_start() || $urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0: write_reg(REG_FRAME_WIDTH, rand_size());
                    1: write_reg(REG_FRAME_HEIGHT, rand_size());
                    2: begin
                        write_reg(REG_FRAME_WIDTH, rand_size());
                        write_reg(REG_FRAME_HEIGHT, rand_size());
                    end
                    3: begin
                        write_reg(REG_FRAME_WIDTH, SIZE_BITS'($urandom_range(0, 1)));
                        write_reg(REG_FRAME_HEIGHT, SIZE_BITS'($urandom_range(0, 1)));
                    end
                    4: begin
                        write_reg(CFG_IDX_BITS'($urandom_range(REG_FRAME_HEIGHT + 1, CFG_IDX_TOP)),
                                  SIZE_BITS'($urandom));
                        write_reg(REG_FRAME_WIDTH, rand_size());
                    end
                    default: begin
                        write_reg(REG_FRAME_HEIGHT, rand_size());
                        write_reg(REG_FRAME_WIDTH, rand_size());
                    end
                endcase
            end
            sample_spread = $urandom_range(0, 2);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_frame(-1, pick < 3);
            end else if (pick < 9) begin
                send_frame($urandom_range(1, board.frame_cols() * (board.frame_rows() + 1) - 1),
                           1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) send_item(1'($urandom), random_sample());
            end
        end

        // Largest sizes: an over-range width through the wrap into its second row,
        // then the first rows of the tallest frame
        settle();
        write_reg(REG_FRAME_WIDTH, 11'h7ff);
        write_reg(REG_FRAME_HEIGHT, 11'd2);
        sample_spread = 2;
        send_frame(board.frame_cols() + 16, 1'b1);
        settle();
        write_reg(REG_FRAME_WIDTH, 11'd2);
        write_reg(REG_FRAME_HEIGHT, 11'd1024);
        send_frame(40, 1'b1);

        settle();
        if (board.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
